// ----- sv/sbr_pkg.sv -----
package sbr_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_MAX_REGION = 128;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MIN    = 2'd2;

  localparam logic [8:0]  RST_WIDTH     = 9'd256;
  localparam logic [8:0]  RST_HEIGHT    = 9'd256;
  localparam logic [7:0]  RST_MIN_SIZE  = 8'd100;
  localparam logic [7:0]  CLEARED_VALUE = 8'd255;
  localparam logic [16:0] COUNT_LIMIT   = 17'd131071;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pixel_index;
    logic [7:0]  pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  pixel_out;
    logic [16:0] removed_count;
    logic        run_done;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } ctrl_status_t;

endpackage

// ----- sv/sbr_ram.sv -----
module sbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/sbr_ctrl.sv -----
module sbr_ctrl
  import sbr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_REGION = DEF_MAX_REGION,
  localparam int unsigned STORE = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned AW    = $clog2(STORE),
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1),
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned LD    = MAX_REGION + 4,
  localparam int unsigned NW    = $clog2(LD)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_word_t     in_data,
  input  logic         out_free,
  input  logic [XW-1:0] img_w,
  input  logic [YW-1:0] img_h,
  input  logic [NW-1:0] thr,
  output ctrl_status_t status,
  output out_word_t    res_data
);

  localparam int unsigned LW = YW + XW + AW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RDWAIT   = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_POP      = 4'd4;
  localparam logic [3:0] S_CUR      = 4'd5;
  localparam logic [3:0] S_NRD      = 4'd6;
  localparam logic [3:0] S_NCK      = 4'd7;
  localparam logic [3:0] S_CLR_RD   = 4'd8;
  localparam logic [3:0] S_CLR_WR   = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [XW-1:0] sx_r, sx_nxt;
  logic [YW-1:0] sy_r, sy_nxt;
  logic [AW-1:0] sidx_r, sidx_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] head_r, head_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] nb_r, nb_nxt;
  logic [16:0]   total_r, total_nxt;
  logic          small_r, small_nxt;
  logic          rdok_r, rdok_nxt;

  logic          img_we, img_re;
  logic [AW-1:0] img_waddr, img_raddr;
  logic [8:0]    img_wdata, img_rdata;
  logic          lst_we, lst_re;
  logic [NW-1:0] lst_waddr, lst_raddr;
  logic [LW-1:0] lst_wdata, lst_rdata;

  logic          accept, in_range;
  logic [YW-1:0] cy;
  logic [XW-1:0] cx;
  logic [AW-1:0] ci, wa;
  logic          nb_ok;
  logic [LW-1:0] nb;
  logic [NW-1:0] n_step;
  logic [17:0]   sum;

  sbr_ram #(.WIDTH(9), .DEPTH(STORE)) u_image (
    .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
    .re(img_re), .raddr(img_raddr), .rdata(img_rdata)
  );

  sbr_ram #(.WIDTH(LW), .DEPTH(LD)) u_list (
    .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .re(lst_re), .raddr(lst_raddr), .rdata(lst_rdata)
  );

  assign in_range = (32'(in_data.pixel_index) < STORE);
  assign accept   = in_valid && in_ready;
  assign cy = cur_r[LW-1 -: YW];
  assign cx = cur_r[AW +: XW];
  assign ci = cur_r[AW-1:0];
  assign wa = AW'(img_w);
  assign sum = 18'(total_r) + 18'(n_r);

  // neighbor k of the current member: left, up, down, right
  always_comb begin
    nb_ok = 1'b0;
    nb    = cur_r;
    case (k_r)
      2'd0: begin
        nb_ok = (cx != '0);
        nb    = {cy, XW'(cx - 1'b1), AW'(ci - 1'b1)};
      end
      2'd1: begin
        nb_ok = (cy != '0);
        nb    = {YW'(cy - 1'b1), cx, AW'(ci - wa)};
      end
      2'd2: begin
        nb_ok = (YW'(cy + 1'b1) < img_h);
        nb    = {YW'(cy + 1'b1), cx, AW'(ci + wa)};
      end
      default: begin
        nb_ok = (XW'(cx + 1'b1) < img_w);
        nb    = {cy, XW'(cx + 1'b1), AW'(ci + 1'b1)};
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sidx_nxt  = sidx_r;
    n_nxt     = n_r;
    head_nxt  = head_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    nb_nxt    = nb_r;
    total_nxt = total_r;
    small_nxt = small_r;
    rdok_nxt  = rdok_r;
    img_we    = 1'b0;
    img_waddr = sidx_r;
    img_wdata = 9'd0;
    img_re    = 1'b0;
    img_raddr = sidx_r;
    lst_we    = 1'b0;
    lst_waddr = n_r;
    lst_wdata = nb_r;
    lst_re    = 1'b0;
    lst_raddr = head_r;
    n_step    = n_r;
    in_ready  = 1'b0;
    status.res_valid = 1'b0;
    res_data  = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = out_free || (in_data.kind == KIND_LOAD) || (in_data.kind == KIND_NONE);
        if (accept) begin
          case (in_data.kind)
            KIND_LOAD: begin
              img_we    = in_range;
              img_waddr = AW'(in_data.pixel_index);
              img_wdata = {1'b0, in_data.pixel_value};
            end
            KIND_READ: begin
              img_re    = 1'b1;
              img_raddr = AW'(in_data.pixel_index);
              rdok_nxt  = in_range;
              state_nxt = S_RDWAIT;
            end
            KIND_RUN: begin
              total_nxt = '0;
              sx_nxt    = '0;
              sy_nxt    = '0;
              sidx_nxt  = '0;
              if (img_w == '0 || img_h == '0 || thr == '0) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDWAIT: begin
        status.res_valid   = 1'b1;
        res_data.pixel_out = rdok_r ? img_rdata[7:0] : 8'd0;
        state_nxt          = S_IDLE;
      end
      S_SCAN_RD: begin
        img_re    = 1'b1;
        img_raddr = sidx_r;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (img_rdata[7:0] == 8'd0) begin
          img_we    = 1'b1;
          img_waddr = sidx_r;
          img_wdata = {1'b1, 8'd0};
          lst_we    = 1'b1;
          lst_waddr = '0;
          lst_wdata = {sy_r, sx_r, sidx_r};
          n_nxt     = NW'(1);
          head_nxt  = '0;
          state_nxt = S_POP;
        end else if (XW'(sx_r + 1'b1) == img_w) begin
          if (YW'(sy_r + 1'b1) == img_h) begin
            state_nxt = S_DONE;
          end else begin
            sx_nxt    = '0;
            sy_nxt    = YW'(sy_r + 1'b1);
            sidx_nxt  = AW'(sidx_r + 1'b1);
            state_nxt = S_SCAN_RD;
          end
        end else begin
          sx_nxt    = XW'(sx_r + 1'b1);
          sidx_nxt  = AW'(sidx_r + 1'b1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_POP: begin
        if (head_r == n_r) begin
          small_nxt = (n_r < thr);
          head_nxt  = '0;
          state_nxt = S_CLR_RD;
        end else begin
          lst_re    = 1'b1;
          lst_raddr = head_r;
          state_nxt = S_CUR;
        end
      end
      S_CUR: begin
        cur_nxt   = lst_rdata;
        k_nxt     = 2'd0;
        state_nxt = S_NRD;
      end
      S_NRD, S_NCK: begin
        if (state_r == S_NRD && nb_ok) begin
          img_re    = 1'b1;
          img_raddr = nb[AW-1:0];
          nb_nxt    = nb;
          state_nxt = S_NCK;
        end else begin
          if (state_r == S_NCK && img_rdata == 9'd0) begin
            img_we    = 1'b1;
            img_waddr = nb_r[AW-1:0];
            img_wdata = {1'b1, 8'd0};
            lst_we    = 1'b1;
            lst_waddr = n_r;
            lst_wdata = nb_r;
            n_step    = NW'(n_r + 1'b1);
          end
          n_nxt = n_step;
          if (k_r == 2'd3) begin
            head_nxt = NW'(head_r + 1'b1);
            if (n_step >= thr) begin
              small_nxt = 1'b0;
              head_nxt  = '0;
              state_nxt = S_CLR_RD;
            end else begin
              state_nxt = S_POP;
            end
          end else begin
            k_nxt     = 2'(k_r + 1'b1);
            state_nxt = S_NRD;
          end
        end
      end
      S_CLR_RD: begin
        if (head_r == n_r) begin
          if (small_r) begin
            total_nxt = (sum > 18'(COUNT_LIMIT)) ? COUNT_LIMIT : sum[16:0];
          end
          if (XW'(sx_r + 1'b1) == img_w) begin
            if (YW'(sy_r + 1'b1) == img_h) begin
              state_nxt = S_DONE;
            end else begin
              sx_nxt    = '0;
              sy_nxt    = YW'(sy_r + 1'b1);
              sidx_nxt  = AW'(sidx_r + 1'b1);
              state_nxt = S_SCAN_RD;
            end
          end else begin
            sx_nxt    = XW'(sx_r + 1'b1);
            sidx_nxt  = AW'(sidx_r + 1'b1);
            state_nxt = S_SCAN_RD;
          end
        end else begin
          lst_re    = 1'b1;
          lst_raddr = head_r;
          state_nxt = S_CLR_WR;
        end
      end
      S_CLR_WR: begin
        img_we    = 1'b1;
        img_waddr = lst_rdata[AW-1:0];
        img_wdata = small_r ? {1'b0, CLEARED_VALUE} : 9'd0;
        head_nxt  = NW'(head_r + 1'b1);
        state_nxt = S_CLR_RD;
      end
      S_DONE: begin
        status.res_valid       = 1'b1;
        res_data.removed_count = total_r;
        res_data.run_done      = 1'b1;
        state_nxt              = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    status.busy = (state_r != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    sidx_r  <= sidx_nxt;
    n_r     <= n_nxt;
    head_r  <= head_nxt;
    k_r     <= k_nxt;
    cur_r   <= cur_nxt;
    nb_r    <= nb_nxt;
    small_r <= small_nxt;
    rdok_r  <= rdok_nxt;
  end

endmodule

// ----- sv/small_blob_removal_top.sv -----
// Small obstacle region removal over a grey map image held in on-chip memory.
// Input channel (in_valid/in_ready/in_data) carries one word per command:
//   load  writes one pixel and gives no result
//   read  returns the pixel through the memory read and output registers
//   run   clears every 4-connected region of zero pixels smaller than
//         min_region_size to 255 and returns the count of cleared pixels
// Loads stream at one word per cycle while no read or run is in progress; a
// read holds the controller until its result goes to the output register.
// A run scans every pixel, walks each zero region it finds and sweeps its
// members; one image memory access per cycle, with a registered read.
// Results leave through one output register (out_valid/out_ready/out_data);
// while it holds a word that is not taken, loads are still accepted but
// reads and runs wait. Configuration (cfg_we/cfg_index/cfg_data) must be
// written only while idle; the block does not enforce this. Width, height
// and size saturate at the built-in maxima. Reset returns the control logic
// to idle, clears the removed count and sets width 256, height 256 and size
// 100. The image memory is not cleared and holds no valid data until loaded.
module small_blob_removal_top
  import sbr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_REGION = DEF_MAX_REGION
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NW = $clog2(MAX_REGION + 4);

  logic [8:0]   cfg_w_r, cfg_h_r;
  logic [7:0]   cfg_min_r;
  logic [XW-1:0] img_w;
  logic [YW-1:0] img_h;
  logic [NW-1:0] thr;
  logic         out_valid_r;
  out_word_t    out_data_r;
  ctrl_status_t status;
  out_word_t    res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= RST_WIDTH;
      cfg_h_r   <= RST_HEIGHT;
      cfg_min_r <= RST_MIN_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_w_r   <= cfg_data;
        CFG_HEIGHT: cfg_h_r   <= cfg_data;
        CFG_MIN:    cfg_min_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign img_w = (32'(cfg_w_r) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(cfg_w_r);
  assign img_h = (32'(cfg_h_r) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(cfg_h_r);
  assign thr   = (32'(cfg_min_r) > MAX_REGION) ? NW'(MAX_REGION) : NW'(cfg_min_r);

  sbr_ctrl #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_REGION(MAX_REGION)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_free(!out_valid_r || out_ready),
    .img_w(img_w), .img_h(img_h), .thr(thr),
    .status(status), .res_data(res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (status.res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(status.res_valid && out_valid_r && !out_ready))
    else $error("result overwrites a word not yet taken");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> !in_ready)
    else $error("input accepted while a command is in progress");

  a_read_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.run_done) |-> (out_data.removed_count == 17'd0))
    else $error("read word carries a count");

endmodule
